// ===== src/trackpad_cursor_delta_corrector_top_macros.svh =====
// Assertion macros for the trackpad cursor delta corrector.
`ifndef TRACKPAD_CURSOR_DELTA_CORRECTOR_TOP_MACROS_SVH
`define TRACKPAD_CURSOR_DELTA_CORRECTOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCDC_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCDC_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tcdc_pkg.sv =====
// Shared types, constants and helper functions of the cursor delta corrector.
package tcdc_pkg;

  localparam int MAX_SLOTS    = 5;
  localparam int FINGER_SLOTS = 5;
  localparam int DELTA_LIMIT  = 300;
  localparam int REPORT_LIMIT = 127;

  localparam int FINGER_W = 48;
  localparam int COORD_W  = 16;
  localparam int DELTA_W  = 10;
  localparam int MOVE_W   = 8;
  localparam int SUM_W    = DELTA_W + 1;
  localparam int P1_W     = SUM_W + 8;
  localparam int P2_W     = P1_W + SUM_W;
  localparam int NUM_W    = 28;
  localparam int MAG_W    = NUM_W - 1;
  localparam int DEN_W    = 15;
  localparam int REM_W    = 16;

  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 80;

  localparam logic [2:0] NO_FINGER = 3'd7;

  // Register indexes.
  localparam logic [2:0] REG_ACCEL  = 3'd0;
  localparam logic [2:0] REG_SPEED  = 3'd1;
  localparam logic [2:0] REG_DIVIS  = 3'd2;
  localparam logic [2:0] REG_SINGLE = 3'd3;
  localparam logic [2:0] REG_MULTI  = 3'd4;

  localparam logic [7:0]  RST_SPEED  = 8'd10;
  localparam logic [7:0]  RST_DIVIS  = 8'd1;
  localparam logic [15:0] RST_SINGLE = 16'd50;
  localparam logic [15:0] RST_MULTI  = 16'd150;

  typedef struct packed {
    logic                      touch_prev;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic                      active;
    logic [COORD_W-1:0]        strength;
  } lane_t;

  function automatic logic signed [DELTA_W-1:0] clamp_delta(input logic signed [COORD_W:0] v);
    logic signed [COORD_W:0] lim;
    lim = (COORD_W+1)'(DELTA_LIMIT);
    if (v > lim)       clamp_delta = DELTA_W'(DELTA_LIMIT);
    else if (v < -lim) clamp_delta = -DELTA_W'(DELTA_LIMIT);
    else               clamp_delta = v[DELTA_W-1:0];
  endfunction

  function automatic logic [DELTA_W-1:0] abs_delta(input logic signed [DELTA_W-1:0] v);
    abs_delta = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
  endfunction

endpackage

// ===== src/tcdc_lane.sv =====
// One finger slot: stored position, clamped delta and activity flag.
module tcdc_lane
  import tcdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FINGER_W-1:0] finger,
  input  logic                upd,
  output lane_t               lane
);

  logic               valid_r;
  logic [COORD_W-1:0] pos_x_r;
  logic [COORD_W-1:0] pos_y_r;

  logic [COORD_W-1:0]      x, y, s;
  logic signed [COORD_W:0] diff_x, diff_y;
  logic                    touch_prev;
  logic [DELTA_W:0]        act_sum;

  assign x = finger[15:0];
  assign y = finger[31:16];
  assign s = finger[47:32];

  assign diff_x     = $signed({1'b0, x}) - $signed({1'b0, pos_x_r});
  assign diff_y     = $signed({1'b0, y}) - $signed({1'b0, pos_y_r});
  assign touch_prev = (s != '0) && valid_r;

  always_comb begin
    lane.touch_prev = touch_prev;
    lane.dx         = touch_prev ? clamp_delta(diff_x) : '0;
    lane.dy         = touch_prev ? clamp_delta(diff_y) : '0;
    lane.strength   = s;
    act_sum         = {1'b0, abs_delta(lane.dx)} + {1'b0, abs_delta(lane.dy)};
    lane.active     = act_sum > (DELTA_W+1)'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (upd) begin
      valid_r <= (s != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (upd && (s != '0)) begin
      pos_x_r <= x;
      pos_y_r <= y;
    end
  end

endmodule

// ===== src/tcdc_div.sv =====
// Bit-serial restoring divider on magnitudes, one quotient bit per cycle.
module tcdc_div
  import tcdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [MAG_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(MAG_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[MAG_W-2:0], ge};
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== src/trackpad_cursor_delta_corrector_top.sv =====
// Top level of the trackpad cursor delta corrector: lanes, merge, scaling and division.
// Steps from input transaction to result valid: merge, two multiply steps, divider start,
//   the divide state for 27 quotient bits, final load. The next input is taken as soon as
//   the result sits in the output register, even if it has not been taken yet.
// Reset (rst_n, synchronous, active low): all slots invalid, cursor slot 0, zero
//   start time, deltas and remainders, registers at their defaults.
`include "trackpad_cursor_delta_corrector_top_macros.svh"
module trackpad_cursor_delta_corrector_top
  import tcdc_pkg::*;
#(
  parameter int FINGER_SLOTS = tcdc_pkg::FINGER_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // finger0..finger4 [239:0] (48 bits each), finger_count [242:240], now_ms [258:243]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // move_x [7:0], move_y [15:8], delta_x [25:16], delta_y [35:26], last_delta_x [45:36],
  // last_delta_y [55:46], peak_strength [71:56], fingers_out [74:72]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LANE = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_GO   = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Configuration registers.
  logic        accel_r;
  logic [7:0]  speed_r;
  logic [7:0]  divis_r;
  logic [15:0] single_r;
  logic [15:0] multi_r;

  // Captured report.
  logic [FINGER_W-1:0] fingers_r [MAX_SLOTS];
  logic [2:0]          count_r;
  logic [15:0]         now_r;

  // Persistent tracking state.
  logic [2:0]               cursor_r;
  logic [15:0]              touch_start_r;
  logic signed [DELTA_W-1:0] prev_dx_r, prev_dy_r;
  logic signed [REM_W-1:0]  rem_x_r, rem_y_r;

  // Per-report work registers.
  logic signed [DELTA_W-1:0] sel_x_r, sel_y_r;
  logic [15:0]               peak_r;
  logic signed [P1_W-1:0]    p1_x_r, p1_y_r;
  logic [DELTA_W:0]          mag_x_r, mag_y_r;
  logic [DEN_W-1:0]          den_r;
  logic                      neg_x_r, neg_y_r;
  logic [MAG_W-1:0]          nmag_x_r, nmag_y_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  lane_t lanes [MAX_SLOTS];

  // Input handshake: take a report only with nothing in flight.
  assign in_tready = (state_r == ST_IDLE);
  // Hold register writes off while a report is being worked on.
  assign cfg_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r  <= 1'b0;
      speed_r  <= RST_SPEED;
      divis_r  <= RST_DIVIS;
      single_r <= RST_SINGLE;
      multi_r  <= RST_MULTI;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACCEL:  accel_r  <= cfg_data[0];
        REG_SPEED:  speed_r  <= cfg_data[7:0];
        REG_DIVIS:  divis_r  <= cfg_data[7:0];
        REG_SINGLE: single_r <= cfg_data;
        REG_MULTI:  multi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the report; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        fingers_r[i] <= in_tdata[i*FINGER_W +: FINGER_W];
      end
      count_r <= in_tdata[242:240];
      now_r   <= in_tdata[258:243];
    end
  end

  // Finger lanes, one per configured slot; unused slots read as empty.
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_lane
    if (g < FINGER_SLOTS) begin : g_on
      tcdc_lane u_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .finger (fingers_r[g]),
        .upd    (state_r == ST_LANE),
        .lane   (lanes[g])
      );
    end else begin : g_off
      assign lanes[g] = '0;
    end
  end

  // Merge stage: first touch, hold-off, cursor selection and peak strength.
  logic                      first_w, hold_w, cur_ok_w;
  logic [15:0]               start_w, elapsed_w, peak_w;
  logic [2:0]                lowest_w, cursor_w;
  logic signed [DELTA_W-1:0] cur_dx_w, cur_dy_w, selx_w, sely_w;

  always_comb begin
    first_w  = 1'b1;
    peak_w   = '0;
    cur_ok_w = 1'b0;
    cur_dx_w = '0;
    cur_dy_w = '0;
    lowest_w = NO_FINGER;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (lanes[i].touch_prev) first_w = 1'b0;
      if (lanes[i].strength > peak_w) peak_w = lanes[i].strength;
      if (cursor_r == 3'(i) && lanes[i].active) begin
        cur_ok_w = 1'b1;
        cur_dx_w = lanes[i].dx;
        cur_dy_w = lanes[i].dy;
      end
    end
    // Scan downward so the lowest active slot wins.
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (lanes[i].active) lowest_w = 3'(i);
    end
    start_w   = ((count_r != 3'd0) && first_w) ? now_r : touch_start_r;
    elapsed_w = now_r - start_w;
    hold_w    = ((count_r == 3'd1) && (elapsed_w < single_r)) ||
                ((count_r >= 3'd2) && (elapsed_w < multi_r));
    selx_w   = '0;
    sely_w   = '0;
    cursor_w = cursor_r;
    if (hold_w) begin
      cursor_w = cursor_r;
    end else if (cur_ok_w) begin
      selx_w = cur_dx_w;
      sely_w = cur_dy_w;
    end else begin
      cursor_w = lowest_w;
    end
  end

  // Scaling: sum with previous delta, times speed, then times |sum| with acceleration.
  logic signed [SUM_W-1:0] sum_x_w, sum_y_w;
  logic signed [P1_W-1:0]  p1x_w, p1y_w;
  logic signed [P2_W-1:0]  p2x_w, p2y_w;
  logic signed [NUM_W-1:0] numx_w, numy_w;
  logic [7:0]              corr_w;

  always_comb begin
    sum_x_w = SUM_W'(sel_x_r) + SUM_W'(prev_dx_r);
    sum_y_w = SUM_W'(sel_y_r) + SUM_W'(prev_dy_r);
    p1x_w   = sum_x_w * $signed({1'b0, speed_r});
    p1y_w   = sum_y_w * $signed({1'b0, speed_r});
    corr_w  = (divis_r == 8'd0) ? 8'd1 : divis_r;
    if (accel_r) begin
      p2x_w = p1_x_r * $signed({1'b0, mag_x_r});
      p2y_w = p1_y_r * $signed({1'b0, mag_y_r});
    end else begin
      p2x_w = P2_W'(p1_x_r);
      p2y_w = P2_W'(p1_y_r);
    end
    numx_w = $signed(p2x_w[NUM_W-1:0]) + NUM_W'(rem_x_r);
    numy_w = $signed(p2y_w[NUM_W-1:0]) + NUM_W'(rem_y_r);
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_LANE: begin
        sel_x_r <= selx_w;
        sel_y_r <= sely_w;
        peak_r  <= peak_w;
      end
      ST_MUL1: begin
        p1_x_r  <= p1x_w;
        p1_y_r  <= p1y_w;
        mag_x_r <= sum_x_w[SUM_W-1] ? SUM_W'(-sum_x_w) : SUM_W'(sum_x_w);
        mag_y_r <= sum_y_w[SUM_W-1] ? SUM_W'(-sum_y_w) : SUM_W'(sum_y_w);
        den_r   <= DEN_W'(corr_w) * (accel_r ? DEN_W'(100) : DEN_W'(5));
      end
      ST_MUL2: begin
        neg_x_r  <= numx_w[NUM_W-1];
        neg_y_r  <= numy_w[NUM_W-1];
        nmag_x_r <= numx_w[NUM_W-1] ? MAG_W'(-numx_w) : MAG_W'(numx_w);
        nmag_y_r <= numy_w[NUM_W-1] ? MAG_W'(-numy_w) : MAG_W'(numy_w);
      end
      default: ;
    endcase
  end

  // Two divider lanes, x and y, run in lockstep.
  logic             div_busy_x, div_busy_y;
  logic [MAG_W-1:0] quo_x, quo_y;
  logic [DEN_W-1:0] drem_x, drem_y;

  tcdc_div u_div_x (
    .clk (clk), .rst_n (rst_n), .start (state_r == ST_GO),
    .num (nmag_x_r), .den (den_r), .busy (div_busy_x), .quo (quo_x), .rem (drem_x)
  );

  tcdc_div u_div_y (
    .clk (clk), .rst_n (rst_n), .start (state_r == ST_GO),
    .num (nmag_y_r), .den (den_r), .busy (div_busy_y), .quo (quo_y), .rem (drem_y)
  );

  // Saturate quotients and restore signs (truncating division).
  logic [MOVE_W-2:0]        satx_w, saty_w;
  logic signed [MOVE_W-1:0] movx_w, movy_w;
  logic signed [REM_W-1:0]  nremx_w, nremy_w;

  always_comb begin
    satx_w  = (quo_x > MAG_W'(REPORT_LIMIT)) ? (MOVE_W-1)'(REPORT_LIMIT) : quo_x[MOVE_W-2:0];
    saty_w  = (quo_y > MAG_W'(REPORT_LIMIT)) ? (MOVE_W-1)'(REPORT_LIMIT) : quo_y[MOVE_W-2:0];
    movx_w  = neg_x_r ? -$signed({1'b0, satx_w}) : $signed({1'b0, satx_w});
    movy_w  = neg_y_r ? -$signed({1'b0, saty_w}) : $signed({1'b0, saty_w});
    nremx_w = neg_x_r ? -$signed({1'b0, drem_x}) : $signed({1'b0, drem_x});
    nremy_w = neg_y_r ? -$signed({1'b0, drem_y}) : $signed({1'b0, drem_y});
  end

  logic fin_load;
  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_LANE;
      ST_LANE: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_GO;
      ST_GO:   state_nxt = ST_DIV;
      ST_DIV:  if (!div_busy_x) state_nxt = ST_FIN;
      ST_FIN:  if (fin_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cursor_r      <= 3'd0;
      touch_start_r <= '0;
      prev_dx_r     <= '0;
      prev_dy_r     <= '0;
      rem_x_r       <= '0;
      rem_y_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Commit tracking state once the lanes have been merged.
      if (state_r == ST_LANE) begin
        cursor_r      <= cursor_w;
        touch_start_r <= start_w;
      end
      if (fin_load) begin
        prev_dx_r   <= sel_x_r;
        prev_dy_r   <= sel_y_r;
        rem_x_r     <= nremx_w;
        rem_y_r     <= nremy_w;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register; holds its transaction until taken.
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data_r <= {5'd0, count_r, peak_r, prev_dy_r, prev_dx_r,
                     sel_y_r, sel_x_r, movy_w, movx_w};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TCDC_AST_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `TCDC_AST_SAME(a_move_range, out_tvalid, (out_tdata[7:0] != 8'h80) && (out_tdata[15:8] != 8'h80), "move beyond limit")
  `TCDC_AST_SAME(a_cursor_legal, state_r == ST_IDLE, (cursor_r < 3'(FINGER_SLOTS)) || (cursor_r == NO_FINGER), "bad cursor slot")
  `TCDC_AST_SAME(a_div_lockstep, 1'b1, div_busy_x == div_busy_y, "dividers out of step")

endmodule
